### hdl/plmao_pkg.sv
// Package for the pixel tone-curve and overlay unit.
// Holds the channel payload structs, the item codes and shared constants.
package plmao_pkg;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [2:0] REG_MAP_BLUE  = 3'd0;
  localparam logic [2:0] REG_MAP_GREEN = 3'd1;
  localparam logic [2:0] REG_MAP_RED   = 3'd2;
  localparam logic [2:0] REG_MAP_ALPHA = 3'd3;
  localparam logic [2:0] REG_OVERLAY   = 3'd4;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  // quotient bits, one restoring step per stage
  localparam int QBITS = 8;

  typedef struct packed {
    logic       func;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] pix_blue;
    logic [7:0] pix_green;
    logic [7:0] pix_red;
    logic [7:0] pix_alpha;
    logic [7:0] ovl_blue;
    logic [7:0] ovl_green;
    logic [7:0] ovl_red;
    logic [7:0] ovl_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
  } out_item_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic       overlay;
    logic [7:0] mb;
    logic [7:0] mg;
    logic [7:0] mr;
    logic [7:0] ma;
    logic [7:0] ob;
    logic [7:0] og;
    logic [7:0] orr;
    logic [7:0] oa;
  } job_t;

  typedef struct packed {
    logic map_blue;
    logic map_green;
    logic map_red;
    logic map_alpha;
    logic overlay;
  } cfg_t;

endpackage

### hdl/plmao_front.sv
// Front end: takes input items, writes the tone table on loads and maps
// pixel channels through it. Uses plmao_pkg.
module plmao_front (
  input  logic                clk,
  input  logic                rst,
  input  plmao_pkg::cfg_t     cfg,
  input  logic                valid,
  output logic                stall,
  input  plmao_pkg::in_item_t data,
  output logic                job_valid,
  input  logic                job_stall,
  output plmao_pkg::job_t     job
);

  logic [7:0] tone_mem_a [256];
  logic [7:0] tone_mem_b [256];
  logic [7:0] tb, tg, tr, ta;
  logic       s1_valid;
  logic       s1_en_b, s1_en_g, s1_en_r, s1_en_a, s1_ovl;
  plmao_pkg::in_item_t s1;
  logic       take;
  logic       adv;

  // one-stage pipe: table read is registered
  assign adv   = !s1_valid || !job_stall;
  assign stall = !adv;
  assign take  = valid && adv;

  // two copies of the table, each read at two addresses per cycle
  always_ff @(posedge clk) begin
    if (take && data.func == plmao_pkg::FUNC_LOAD) begin
      tone_mem_a[data.table_index] <= data.table_value;
      tone_mem_b[data.table_index] <= data.table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tb <= tone_mem_a[data.pix_blue];
      tg <= tone_mem_a[data.pix_green];
      tr <= tone_mem_b[data.pix_red];
      ta <= tone_mem_b[data.pix_alpha];
      s1 <= data;
      s1_en_b <= cfg.map_blue;
      s1_en_g <= cfg.map_green;
      s1_en_r <= cfg.map_red;
      s1_en_a <= cfg.map_alpha;
      s1_ovl  <= cfg.overlay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take && data.func == plmao_pkg::FUNC_PIXEL;
    end
  end

  assign job_valid = s1_valid;
  always_comb begin
    job.overlay = s1_ovl;
    job.mb  = s1_en_b ? tb : s1.pix_blue;
    job.mg  = s1_en_g ? tg : s1.pix_green;
    job.mr  = s1_en_r ? tr : s1.pix_red;
    job.ma  = s1_en_a ? ta : s1.pix_alpha;
    job.ob  = s1.ovl_blue;
    job.og  = s1.ovl_green;
    job.orr = s1.ovl_red;
    job.oa  = s1.ovl_alpha;
  end

endmodule

### hdl/plmao_queue.sv
// Short queue between front and back ends, two entries.
// Uses plmao_pkg for the job type.
module plmao_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  plmao_pkg::job_t in_job,
  output logic            out_valid,
  input  logic            out_stall,
  output plmao_pkg::job_t out_job
);

  plmao_pkg::job_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_stall  = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign out_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/plmao_back.sv
// Back end: alpha-over compositing with a pipelined restoring divider.
// Uses plmao_pkg. One job per cycle while the output is not stalled.
module plmao_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_stall,
  input  plmao_pkg::job_t   job,
  output logic              valid,
  input  logic              stall,
  output plmao_pkg::out_item_t data
);

  localparam int NS = plmao_pkg::QBITS;
  localparam int DEPTH = NS + 3;

  logic adv;
  logic [DEPTH-1:0] vld;

  // stage A: products
  logic        a_ovl;
  logic [7:0]  a_mb, a_mg, a_mr;
  logic [15:0] a_t1, a_oa255;
  logic [15:0] a_pb, a_pg, a_pr;

  // stage B: t2 and scaled overlay products
  logic        b_ovl;
  logic [7:0]  b_mb, b_mg, b_mr;
  logic [15:0] b_t1;
  logic [16:0] b_t2;
  logic [23:0] b_pb, b_pg, b_pr;

  // stage C: numerators and alpha
  logic        c_ovl;
  logic [7:0]  c_mb, c_mg, c_mr;
  logic [16:0] c_t2;
  logic [24:0] c_nb, c_ng, c_nr;
  logic [7:0]  c_alpha_q;

  // divider stages
  logic        d_ovl   [NS+1];
  logic [7:0]  d_mb    [NS+1];
  logic [7:0]  d_mg    [NS+1];
  logic [7:0]  d_mr    [NS+1];
  logic [7:0]  d_al    [NS+1];
  logic [16:0] d_t2    [NS+1];
  logic [24:0] d_rem   [NS+1][3];
  logic [7:0]  d_q     [NS+1][3];

  assign adv       = !vld[DEPTH-1] || !stall;
  assign job_stall = !adv;
  assign valid     = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ovl   <= job.overlay;
      a_mb    <= job.mb;
      a_mg    <= job.mg;
      a_mr    <= job.mr;
      a_t1    <= 16'(job.ma) * 16'(plmao_pkg::FULL_SCALE - job.oa);
      a_oa255 <= 16'(job.oa) * 16'(plmao_pkg::FULL_SCALE);
      a_pb    <= 16'(job.ob) * 16'(job.oa);
      a_pg    <= 16'(job.og) * 16'(job.oa);
      a_pr    <= 16'(job.orr) * 16'(job.oa);

      b_ovl <= a_ovl;
      b_mb  <= a_mb;
      b_mg  <= a_mg;
      b_mr  <= a_mr;
      b_t1  <= a_t1;
      b_t2  <= 17'(a_t1) + 17'(a_oa255);
      b_pb  <= 24'(a_pb) * 24'(plmao_pkg::FULL_SCALE);
      b_pg  <= 24'(a_pg) * 24'(plmao_pkg::FULL_SCALE);
      b_pr  <= 24'(a_pr) * 24'(plmao_pkg::FULL_SCALE);

      c_ovl <= b_ovl;
      c_mb  <= b_mb;
      c_mg  <= b_mg;
      c_mr  <= b_mr;
      c_t2  <= b_t2;
      c_nb  <= 25'(b_pb) + 25'(24'(b_t1) * 24'(b_mb));
      c_ng  <= 25'(b_pg) + 25'(24'(b_t1) * 24'(b_mg));
      c_nr  <= 25'(b_pr) + 25'(24'(b_t1) * 24'(b_mr));
      // t2 <= 65025, so t2/255 = ((t2 + 1) * 257) >> 16 exactly
      c_alpha_q <= 8'((25'(b_t2) * 25'd257 + 25'd257) >> 16);
    end
  end

  // entry of the divider chain
  always_comb begin
    d_ovl[0]    = c_ovl;
    d_mb[0]     = c_mb;
    d_mg[0]     = c_mg;
    d_mr[0]     = c_mr;
    d_al[0]     = c_alpha_q;
    d_t2[0]     = c_t2;
    d_rem[0][0] = c_nb;
    d_rem[0][1] = c_ng;
    d_rem[0][2] = c_nr;
    d_q[0][0]   = '0;
    d_q[0][1]   = '0;
    d_q[0][2]   = '0;
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int SH = NS - 1 - s;
    logic [24:0] rem_n [3];
    logic [7:0]  q_n   [3];
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (d_rem[s][c] >= (25'(d_t2[s]) << SH)) begin
          rem_n[c] = d_rem[s][c] - (25'(d_t2[s]) << SH);
          q_n[c]   = d_q[s][c] | (8'd1 << SH);
        end else begin
          rem_n[c] = d_rem[s][c];
          q_n[c]   = d_q[s][c];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_ovl[s+1] <= d_ovl[s];
        d_mb[s+1]  <= d_mb[s];
        d_mg[s+1]  <= d_mg[s];
        d_mr[s+1]  <= d_mr[s];
        d_al[s+1]  <= d_al[s];
        d_t2[s+1]  <= d_t2[s];
        for (int c = 0; c < 3; c++) begin
          d_rem[s+1][c] <= rem_n[c];
          d_q[s+1][c]   <= q_n[c];
        end
      end
    end
  end

  always_comb begin
    if (!d_ovl[NS]) begin
      data.out_blue  = d_mb[NS];
      data.out_green = d_mg[NS];
      data.out_red   = d_mr[NS];
      data.out_alpha = d_al[NS];
    end else if (d_al[NS] == 8'd0) begin
      data.out_blue  = d_mb[NS];
      data.out_green = d_mg[NS];
      data.out_red   = d_mr[NS];
      data.out_alpha = 8'd0;
    end else begin
      data.out_blue  = d_q[NS][0];
      data.out_green = d_q[NS][1];
      data.out_red   = d_q[NS][2];
      data.out_alpha = d_al[NS];
    end
  end

endmodule

### hdl/pixel_lut_map_alpha_overlay_unit.sv
// Tone-curve lookup with alpha-over compositing, top level.
// Pixel path from input to result: table read, queue, three product stages,
// eight divider stages. Throughput: one item per cycle while out_stall is low;
// the divider is fully pipelined, one quotient bit per stage.
// Reset clears the enables and all valid state; the tone table is not cleared.
module pixel_lut_map_alpha_overlay_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plmao_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plmao_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic                 cfg_data
);

  plmao_pkg::cfg_t cfg;
  logic            fj_valid, fj_stall, qj_valid, qj_stall;
  plmao_pkg::job_t fj, qj, qj_fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plmao_pkg::REG_MAP_BLUE:  cfg.map_blue  <= cfg_data;
        plmao_pkg::REG_MAP_GREEN: cfg.map_green <= cfg_data;
        plmao_pkg::REG_MAP_RED:   cfg.map_red   <= cfg_data;
        plmao_pkg::REG_MAP_ALPHA: cfg.map_alpha <= cfg_data;
        plmao_pkg::REG_OVERLAY:   cfg.overlay   <= cfg_data;
        default: ;
      endcase
    end
  end

  plmao_front u_front (
    .clk, .rst, .cfg,
    .valid(in_valid), .stall(in_stall), .data(in_data),
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
  );

  plmao_queue u_queue (
    .clk, .rst,
    .in_valid(fj_valid), .in_stall(fj_stall), .in_job(fj),
    .out_valid(qj_valid), .out_stall(qj_stall), .out_job(qj)
  );

  // without overlay, route mapped alpha through as oa=0 so t2/255 = ma
  always_comb begin
    qj_fix = qj;
    if (!qj.overlay) begin
      qj_fix.oa = 8'd0;
    end
  end

  plmao_back u_back (
    .clk, .rst,
    .job_valid(qj_valid), .job_stall(qj_stall), .job(qj_fix),
    .valid(out_valid), .stall(out_stall), .data(out_data)
  );

endmodule

### sim/pixel_lut_map_alpha_overlay_unit_tb.sv
// Testbench for the pixel tone-curve and overlay unit.
// Drives load and pixel transactions with random gaps and output stalls, checks
// every result against a local tone-map and alpha-over predictor. Needs plmao_pkg.
module pixel_lut_map_alpha_overlay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  plmao_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  plmao_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic      cfg_data = 1'b0;

  logic [7:0] curve [256];
  plmao_pkg::cfg_t      mode;
  plmao_pkg::out_item_t pending_pixels [$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         stall_style = 0;

  always #2 clk = ~clk;

  pixel_lut_map_alpha_overlay_unit dut (.*);

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [7:0] tone(input logic en, input logic [7:0] v);
    return en ? curve[v] : v;
  endfunction

  function automatic plmao_pkg::out_item_t composite(input plmao_pkg::in_item_t it);
    plmao_pkg::out_item_t r;
    logic [31:0] mb, mg, mr, ma, oa, t1, t2, alpha;
    mb = 32'(tone(mode.map_blue, it.pix_blue));
    mg = 32'(tone(mode.map_green, it.pix_green));
    mr = 32'(tone(mode.map_red, it.pix_red));
    ma = 32'(tone(mode.map_alpha, it.pix_alpha));
    r = {mb[7:0], mg[7:0], mr[7:0], ma[7:0]};
    if (!mode.overlay) return r;
    oa = 32'(it.ovl_alpha);
    t1 = ma * (255 - oa);
    t2 = t1 + 255 * oa;
    alpha = t2 / 255;
    if (alpha > 0) begin
      r.out_blue  = 8'((255 * it.ovl_blue * oa + t1 * mb) / t2);
      r.out_green = 8'((255 * it.ovl_green * oa + t1 * mg) / t2);
      r.out_red   = 8'((255 * it.ovl_red * oa + t1 * mr) / t2);
    end
    r.out_alpha = alpha[7:0];
    return r;
  endfunction

  // result checker and output stall pattern
  always @(posedge clk) begin
    plmao_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report("unexpected result, blue", out_data.out_blue, 8'd0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.out_blue !== want.out_blue) report("blue", out_data.out_blue, want.out_blue);
          if (out_data.out_green !== want.out_green)
            report("green", out_data.out_green, want.out_green);
          if (out_data.out_red !== want.out_red) report("red", out_data.out_red, want.out_red);
          if (out_data.out_alpha !== want.out_alpha)
            report("alpha", out_data.out_alpha, want.out_alpha);
        end
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
      if (($urandom_range(0, 63)) == 0) stall_style <= $urandom_range(0, 2);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input plmao_pkg::in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.func == plmao_pkg::FUNC_LOAD) begin
      curve[it.table_index] = it.table_value;
    end else begin
      pending_pixels.push_back(composite(it));
    end
  endtask

  task automatic pause();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input plmao_pkg::cfg_t m);
    logic [4:0] bits;
    bits = m;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= bits[4 - i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    mode = m;
  endtask

  function automatic plmao_pkg::in_item_t rand_pixel();
    plmao_pkg::in_item_t it;
    it = $bits(plmao_pkg::in_item_t)'({$urandom, $urandom, $urandom});
    it.func = plmao_pkg::FUNC_PIXEL;
    return it;
  endfunction

  function automatic plmao_pkg::in_item_t load_item(input int idx, input int val);
    plmao_pkg::in_item_t it;
    it = $bits(plmao_pkg::in_item_t)'({$urandom, $urandom, $urandom});
    it.func = plmao_pkg::FUNC_LOAD;
    it.table_index = 8'(idx);
    it.table_value = 8'(val);
    return it;
  endfunction

  task automatic test_fill_table();
    for (int i = 0; i < 256; i++) send(load_item(i, $urandom_range(0, 255)));
    drain();
  endtask

  task automatic test_extremes();
    plmao_pkg::in_item_t it;
    plmao_pkg::cfg_t m;
    m = '1;
    write_mode(m);
    // corners of pixel alpha, overlay alpha, pixel blue and overlay blue
    for (int k = 0; k < 16; k++) begin
      it = rand_pixel();
      it.pix_alpha = (k[0]) ? 8'hff : 8'h00;
      it.ovl_alpha = (k[1]) ? 8'hff : 8'h00;
      it.pix_blue = k[2] ? 8'hff : 8'h00;
      it.ovl_blue = k[3] ? 8'hff : 8'h00;
      send(it);
    end
    // a reload mid-stream, then pixels read the fresh entry
    send(load_item(0, 255));
    send(load_item(255, 0));
    for (int k = 0; k < 4; k++) begin
      it = rand_pixel();
      it.pix_alpha = k[0] ? 8'hff : 8'h00;
      send(it);
    end
    drain();
    write_mode('0);
    it = '1;
    send(it);
    send(plmao_pkg::in_item_t'({1'b1, 80'h0}));
    drain();
  endtask

  task automatic test_random(input int count);
    int gap;
    int burst;
    plmao_pkg::in_item_t it;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        repeat (gap) pause();
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 9) == 0) it = load_item($urandom_range(0, 255), $urandom);
      else begin
        it = rand_pixel();
        case ($urandom_range(0, 5))
          0: it.ovl_alpha = 8'h00;
          1: it.ovl_alpha = 8'hff;
          2: it.pix_alpha = 8'h00;
          default: ;
        endcase
      end
      send(it);
      if (n == count / 2) drain();
    end
    drain();
  endtask

  task automatic test_mode_sweep();
    plmao_pkg::cfg_t m;
    for (int p = 0; p < 4; p++) begin
      m = plmao_pkg::cfg_t'($urandom_range(0, 31));
      write_mode(m);
      test_random(55);
    end
    write_mode('1);
    test_random(50);
  endtask

  initial begin
    mode = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode('0);
    test_fill_table();
    test_extremes();
    test_mode_sweep();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
